// File: hw/rtl/letter_modexp_cipher_top_macros.svh
// ---------------------------------------------------------------------------
// letter modexp cipher assertion macros
// property wrappers that vanish in synthesis
// ---------------------------------------------------------------------------
`ifndef LETTER_MODEXP_CIPHER_TOP_MACROS_SVH
`define LETTER_MODEXP_CIPHER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define LMC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define LMC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define LMC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define LMC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: hw/rtl/lmc_pkg.sv
// ---------------------------------------------------------------------------
// lmc_pkg
// shared widths, codes, types and the modular reduction step
// ---------------------------------------------------------------------------
package lmc_pkg;

  localparam int MOD_WIDTH  = 16;
  localparam int EXP_BITS   = 16;
  localparam int RED_PER_ST = 4;
  localparam int RED_STAGES = (MOD_WIDTH + RED_PER_ST - 1) / RED_PER_ST;

  localparam logic [7:0] SPACE_CODE  = 8'd32;
  localparam logic [7:0] LOWER_FIRST = 8'd97;
  localparam logic [7:0] LOWER_LAST  = 8'd122;
  localparam logic [7:0] UPPER_FIRST = 8'd65;
  localparam logic [7:0] UPPER_LAST  = 8'd90;
  localparam logic [7:0] LOWER_BASE  = 8'd96;
  localparam logic [7:0] UPPER_BASE  = 8'd64;

  localparam logic [1:0] CLS_SPACE = 2'd0;
  localparam logic [1:0] CLS_LOWER = 2'd1;
  localparam logic [1:0] CLS_UPPER = 2'd2;
  localparam logic [1:0] CLS_OTHER = 2'd3;

  localparam logic REG_EXPONENT = 1'b0;
  localparam logic REG_MODULUS  = 1'b1;

  typedef logic [MOD_WIDTH-1:0]   word_t;
  typedef logic [2*MOD_WIDTH-1:0] dword_t;

  typedef struct packed {
    logic [1:0] cls;
    logic [7:0] chr;
  } meta_t;

  // four restoring steps, shifts kstart down to kstart-3
  function automatic dword_t red_steps(dword_t x, word_t m, int kstart);
    dword_t r;
    dword_t t;
    int     k;
    r = x;
    for (int i = 0; i < RED_PER_ST; i++) begin
      k = kstart - i;
      if (k >= 0) begin
        t = dword_t'(m) << k;
        if (r >= t) begin
          r = r - t;
        end
      end
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/letter_modexp_cipher_top.sv
// ---------------------------------------------------------------------------
// letter_modexp_cipher_top
// per-byte letter cipher: letter index raised to exponent modulo modulus
// ---------------------------------------------------------------------------
// a text word enters on char_in when text_valid is high and text_stall low;
// one cipher word leaves on residue/char_class/byte_out when cipher_valid is
// high and cipher_stall low. every text word gives exactly one cipher word
// the pipeline is an entry stage, sixteen square-and-multiply steps of
// five stages each (one multiply stage, four stages of four restoring
// reduction steps) and the output register
// throughput is one word per cycle unless stalled; all stages move together
// when cipher_stall is high and a cipher word is waiting, every stage holds
// and text_stall is raised, so nothing is lost or repeated
// exponent and modulus are written through wr_en/wr_index/wr_data, used live;
// the user must change them only while the pipeline is empty, which the block
// does not enforce. reset clears all valid bits, sets exponent 3, modulus 33
// ---------------------------------------------------------------------------
`include "letter_modexp_cipher_top_macros.svh"

module letter_modexp_cipher_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [15:0] wr_data,
  input  logic        text_valid,
  output logic        text_stall,
  input  logic [7:0]  char_in,
  output logic        cipher_valid,
  input  logic        cipher_stall,
  output logic [15:0] residue,
  output logic [1:0]  char_class,
  output logic [7:0]  byte_out
);

  localparam int NB = lmc_pkg::EXP_BITS;

  logic [15:0]    public_exponent;
  logic [15:0]    modulus;
  lmc_pkg::word_t m;
  logic           en;

  always_ff @(posedge clk) begin
    if (rst) begin
      public_exponent <= 16'd3;
      modulus         <= 16'd33;
    end else if (wr_en) begin
      case (wr_index)
        lmc_pkg::REG_EXPONENT: public_exponent <= wr_data;
        lmc_pkg::REG_MODULUS:  modulus         <= wr_data;
        default: ;
      endcase
    end
  end

  assign m          = lmc_pkg::word_t'(modulus);
  assign en         = !(cipher_valid && cipher_stall);
  assign text_stall = !en;

  // classify and reduce the letter index
  logic [1:0]      cls_c;
  logic [7:0]      idx_c;
  lmc_pkg::dword_t sq_c;

  always_comb begin
    cls_c = lmc_pkg::CLS_OTHER;
    idx_c = 8'd0;
    if (char_in == lmc_pkg::SPACE_CODE) begin
      cls_c = lmc_pkg::CLS_SPACE;
    end else if (char_in >= lmc_pkg::LOWER_FIRST && char_in <= lmc_pkg::LOWER_LAST) begin
      cls_c = lmc_pkg::CLS_LOWER;
      idx_c = char_in - lmc_pkg::LOWER_BASE;
    end else if (char_in >= lmc_pkg::UPPER_FIRST && char_in <= lmc_pkg::UPPER_LAST) begin
      cls_c = lmc_pkg::CLS_UPPER;
      idx_c = char_in - lmc_pkg::UPPER_BASE;
    end
    // index below 32, so shifts four down to zero suffice
    sq_c = lmc_pkg::red_steps(lmc_pkg::dword_t'(idx_c), m, 4);
    sq_c = lmc_pkg::red_steps(sq_c, m, 0);
  end

  logic           v_w    [0:NB];
  lmc_pkg::word_t acc_w  [0:NB];
  lmc_pkg::word_t sq_w   [0:NB];
  lmc_pkg::meta_t meta_w [0:NB];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_w[0] <= 1'b0;
    end else if (en) begin
      v_w[0] <= text_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_w[0]      <= lmc_pkg::word_t'(1);
      sq_w[0]       <= sq_c[lmc_pkg::MOD_WIDTH-1:0];
      meta_w[0].cls <= cls_c;
      meta_w[0].chr <= char_in;
    end
  end

  for (genvar b = 0; b < NB; b++) begin : g_step
    lmc_step u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .v_in     (v_w[b]),
      .acc_in   (acc_w[b]),
      .sq_in    (sq_w[b]),
      .meta_in  (meta_w[b]),
      .ebit     (public_exponent[b]),
      .m        (m),
      .v_out    (v_w[b+1]),
      .acc_out  (acc_w[b+1]),
      .sq_out   (sq_w[b+1]),
      .meta_out (meta_w[b+1])
    );
  end

  // output register
  logic           letter;
  lmc_pkg::word_t res_c;
  logic [7:0]     base_c;

  assign letter = (meta_w[NB].cls == lmc_pkg::CLS_LOWER) ||
                  (meta_w[NB].cls == lmc_pkg::CLS_UPPER);
  assign base_c = (meta_w[NB].cls == lmc_pkg::CLS_LOWER) ? lmc_pkg::LOWER_BASE
                                                         : lmc_pkg::UPPER_BASE;
  assign res_c  = (letter && m > lmc_pkg::word_t'(1)) ? acc_w[NB] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_valid <= 1'b0;
    end else if (en) begin
      cipher_valid <= v_w[NB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      residue    <= 16'(res_c);
      char_class <= meta_w[NB].cls;
      byte_out   <= letter ? res_c[7:0] + base_c : meta_w[NB].chr;
    end
  end

  `LMC_ASSERT_NEXT(a_entry_valid, clk, rst, text_valid && !text_stall, v_w[0])
  `LMC_ASSERT_IMPLY(a_nonletter_zero, clk, rst,
    cipher_valid && (char_class == lmc_pkg::CLS_SPACE || char_class == lmc_pkg::CLS_OTHER),
    residue == 16'd0)
  `LMC_ASSERT_IMPLY(a_residue_range, clk, rst,
    cipher_valid && modulus > 16'd1, residue < modulus)

endmodule

// File: hw/rtl/lmc_step.sv
// ---------------------------------------------------------------------------
// lmc_step
// one exponent bit: multiply stage followed by pipelined reduction stages
// ---------------------------------------------------------------------------
module lmc_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                v_in,
  input  lmc_pkg::word_t      acc_in,
  input  lmc_pkg::word_t      sq_in,
  input  lmc_pkg::meta_t      meta_in,
  input  logic                ebit,
  input  lmc_pkg::word_t      m,
  output logic                v_out,
  output lmc_pkg::word_t      acc_out,
  output lmc_pkg::word_t      sq_out,
  output lmc_pkg::meta_t      meta_out
);

  localparam int RS = lmc_pkg::RED_STAGES;

  logic            v    [0:RS];
  lmc_pkg::dword_t a    [0:RS];
  lmc_pkg::dword_t s    [0:RS];
  lmc_pkg::meta_t  meta [0:RS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= RS; i++) v[i] <= 1'b0;
    end else if (en) begin
      v[0] <= v_in;
      for (int i = 1; i <= RS; i++) v[i] <= v[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a[0]    <= ebit ? lmc_pkg::dword_t'(acc_in) * lmc_pkg::dword_t'(sq_in)
                      : lmc_pkg::dword_t'(acc_in);
      s[0]    <= lmc_pkg::dword_t'(sq_in) * lmc_pkg::dword_t'(sq_in);
      meta[0] <= meta_in;
      for (int i = 1; i <= RS; i++) begin
        a[i]    <= lmc_pkg::red_steps(a[i-1], m,
                     lmc_pkg::MOD_WIDTH - 1 - lmc_pkg::RED_PER_ST * (i - 1));
        s[i]    <= lmc_pkg::red_steps(s[i-1], m,
                     lmc_pkg::MOD_WIDTH - 1 - lmc_pkg::RED_PER_ST * (i - 1));
        meta[i] <= meta[i-1];
      end
    end
  end

  assign v_out    = v[RS];
  assign acc_out  = a[RS][lmc_pkg::MOD_WIDTH-1:0];
  assign sq_out   = s[RS][lmc_pkg::MOD_WIDTH-1:0];
  assign meta_out = meta[RS];

endmodule

// File: test/tb_letter_modexp_cipher_top.sv
// ---------------------------------------------------------------------------
// tb_letter_modexp_cipher_top
// checks the letter cipher word by word against a square-and-multiply
// predictor, over several exponent/modulus settings, with random idling
// ---------------------------------------------------------------------------
module tb_letter_modexp_cipher_top;

  localparam int LATENCY = 82;

  typedef struct {
    logic [15:0] res;
    logic [1:0]  cls;
    logic [7:0]  chr;
  } cipher_word_t;

  typedef struct {
    logic [7:0]  chr;
    logic        typed;
    logic [15:0] res;
    logic [1:0]  cls;
    logic [7:0]  bout;
  } text_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        wr_en = 1'b0;
  logic        wr_index = lmc_pkg::REG_EXPONENT;
  logic [15:0] wr_data = '0;
  logic        text_valid = 1'b0;
  logic        text_stall;
  logic [7:0]  char_in = '0;
  logic        cipher_valid;
  logic        cipher_stall = 1'b0;
  logic [15:0] residue;
  logic [1:0]  char_class;
  logic [7:0]  byte_out;

  logic [15:0] exp_reg;
  logic [15:0] mod_reg;
  cipher_word_t cipher_queue[$];
  int  fails = 0;
  bit  calm = 1'b0;

  letter_modexp_cipher_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [15:0] power_mod(logic [15:0] b, logic [15:0] e,
                                            logic [15:0] m);
    logic [31:0] acc;
    logic [31:0] sq;
    if (m < 2) return '0;
    acc = 1;
    sq  = b % m;
    for (int i = 0; i < 16; i++) begin
      if (e[i]) acc = (acc * sq) % m;
      sq = (sq * sq) % m;
    end
    return acc[15:0];
  endfunction

  function automatic cipher_word_t encipher(logic [7:0] c);
    cipher_word_t w;
    w.res = '0;
    w.chr = c;
    if (c == lmc_pkg::SPACE_CODE) begin
      w.cls = lmc_pkg::CLS_SPACE;
    end else if (c >= lmc_pkg::LOWER_FIRST && c <= lmc_pkg::LOWER_LAST) begin
      w.cls = lmc_pkg::CLS_LOWER;
      w.res = power_mod(16'(c - lmc_pkg::LOWER_BASE), exp_reg, mod_reg);
      w.chr = 8'(w.res + lmc_pkg::LOWER_BASE);
    end else if (c >= lmc_pkg::UPPER_FIRST && c <= lmc_pkg::UPPER_LAST) begin
      w.cls = lmc_pkg::CLS_UPPER;
      w.res = power_mod(16'(c - lmc_pkg::UPPER_BASE), exp_reg, mod_reg);
      w.chr = 8'(w.res + lmc_pkg::UPPER_BASE);
    end else begin
      w.cls = lmc_pkg::CLS_OTHER;
    end
    return w;
  endfunction

  task automatic write_reg(logic idx, logic [15:0] val);
    @(negedge clk);
    wr_en = 1'b1;
    wr_index = idx;
    wr_data = val;
    @(negedge clk);
    wr_en = 1'b0;
    if (idx == lmc_pkg::REG_EXPONENT) exp_reg = val;
    else mod_reg = val;
  endtask

  task automatic drain();
    text_valid = 1'b0;
    while (cipher_queue.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  // one text word, called at a falling edge; valid stays up for the next word
  task automatic send_text(logic [7:0] c, bit typed, cipher_word_t tw);
    while (!calm && $urandom_range(99) < 12) begin
      text_valid = 1'b0;
      @(negedge clk);
    end
    text_valid = 1'b1;
    char_in = c;
    cipher_queue.push_back(typed ? tw : encipher(c));
    @(posedge clk);
    while (text_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_text(int n);
    cipher_word_t none;
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: c = 8'($urandom_range(lmc_pkg::LOWER_FIRST, lmc_pkg::LOWER_LAST));
        1: c = 8'($urandom_range(lmc_pkg::UPPER_FIRST, lmc_pkg::UPPER_LAST));
        2: c = lmc_pkg::SPACE_CODE;
        default: c = 8'($urandom);
      endcase
      send_text(c, 1'b0, none);
    end
  endtask

  // receiver: random stall, compare on accepted words
  always @(negedge clk) begin
    cipher_stall <= !calm && ($urandom_range(99) < 12);
  end

  always @(posedge clk) begin
    cipher_word_t w;
    if (!rst && cipher_valid && !cipher_stall) begin
      if (cipher_queue.size() == 0) begin
        $display("%0t unexpected word: residue %0d class %0d byte %0d",
                 $time, residue, char_class, byte_out);
        fails++;
      end else begin
        w = cipher_queue.pop_front();
        if (residue !== w.res) begin
          $display("%0t residue: expected %0d actual %0d", $time, w.res, residue);
          fails++;
        end
        if (char_class !== w.cls) begin
          $display("%0t class: expected %0d actual %0d", $time, w.cls, char_class);
          fails++;
        end
        if (byte_out !== w.chr) begin
          $display("%0t byte: expected %0d actual %0d", $time, w.chr, byte_out);
          fails++;
        end
      end
    end
  end

  text_row_t rows[] = '{
    '{8'd32,  1'b1, 16'd0,  lmc_pkg::CLS_SPACE, 8'd32},
    '{8'd0,   1'b1, 16'd0,  lmc_pkg::CLS_OTHER, 8'd0},
    '{8'd255, 1'b1, 16'd0,  lmc_pkg::CLS_OTHER, 8'd255},
    '{8'd97,  1'b1, 16'd1,  lmc_pkg::CLS_LOWER, 8'd97},
    '{8'd98,  1'b1, 16'd8,  lmc_pkg::CLS_LOWER, 8'd104},
    '{8'd122, 1'b0, 16'd0,  lmc_pkg::CLS_LOWER, 8'd0},
    '{8'd65,  1'b1, 16'd1,  lmc_pkg::CLS_UPPER, 8'd65},
    '{8'd90,  1'b0, 16'd0,  lmc_pkg::CLS_UPPER, 8'd0},
    '{8'd64,  1'b1, 16'd0,  lmc_pkg::CLS_OTHER, 8'd64},
    '{8'd91,  1'b1, 16'd0,  lmc_pkg::CLS_OTHER, 8'd91},
    '{8'd96,  1'b1, 16'd0,  lmc_pkg::CLS_OTHER, 8'd96},
    '{8'd123, 1'b1, 16'd0,  lmc_pkg::CLS_OTHER, 8'd123},
    '{8'd128, 1'b1, 16'd0,  lmc_pkg::CLS_OTHER, 8'd128}
  };

  initial begin
    cipher_word_t tw;
    exp_reg = 16'd3;
    mod_reg = 16'd33;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    foreach (rows[i]) begin
      tw.res = rows[i].res;
      tw.cls = rows[i].cls;
      tw.chr = rows[i].bout;
      send_text(rows[i].chr, rows[i].typed, tw);
    end
    drain();
    // exponent zero, modulus zero and one, large values for byte wrap
    write_reg(lmc_pkg::REG_EXPONENT, 16'd0);
    write_reg(lmc_pkg::REG_MODULUS, 16'd65535);
    random_text(20);
    drain();
    write_reg(lmc_pkg::REG_MODULUS, 16'd0);
    write_reg(lmc_pkg::REG_EXPONENT, 16'd65535);
    random_text(15);
    drain();
    write_reg(lmc_pkg::REG_MODULUS, 16'd1);
    random_text(15);
    drain();
    write_reg(lmc_pkg::REG_MODULUS, 16'd65521);
    write_reg(lmc_pkg::REG_EXPONENT, 16'd17);
    random_text(100);
    // sender holds off until everything has come out
    text_valid = 1'b0;
    while (cipher_queue.size() != 0) @(negedge clk);
    calm = 1'b1;
    random_text(100);
    calm = 1'b0;
    drain();
    for (int p = 0; p < 4; p++) begin
      write_reg(lmc_pkg::REG_EXPONENT, 16'($urandom));
      write_reg(lmc_pkg::REG_MODULUS, 16'($urandom_range(2, 65535)));
      random_text(95);
      drain();
    end
    if (fails == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
